@@ design/apba_pkg.sv @@
// shared types, codes and helpers of the address pool bitmap allocator
package apba_pkg;

  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_LAST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DYN_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DYN_FIRST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DYN_LAST   = 3'd4;

  localparam logic [1:0] CMD_STATIC  = 2'd0;
  localparam logic [1:0] CMD_DYNAMIC = 2'd1;
  localparam logic [1:0] CMD_RECLAIM = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO      = 2'd1;
  localparam logic [1:0] ST_REJECT    = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] pool_first;
    logic [ADDR_W:0]   eff_last;
    logic [ADDR_W-1:0] dyn_first;
    logic [ADDR_W-1:0] dyn_last;
    logic              dyn_ok;
    logic              cursor_load;
  } cfg_t;

  function automatic logic in_pool(input logic [ADDR_W-1:0] a,
                                   input logic [ADDR_W-1:0] first,
                                   input logic [ADDR_W:0]   last);
    return (a >= first) && ({1'b0, a} <= last);
  endfunction

endpackage

@@ design/address_pool_bitmap_allocator.sv @@
// address pool bitmap allocator: sequencer around the used/free bitmap ram
// states from accept to result valid: reclaim and rejects go from check to done,
// a static request through a ram read and an evaluate state, a dynamic request
// through a ram read and an evaluate state per probed position; the next item
// is taken in the idle state after done loads the result into a free output register
// after reset a clearing pass writes every bitmap entry
module address_pool_bitmap_allocator #(
  parameter int POOL_SIZE = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [apba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apba_pkg::ADDR_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     cmd,
  input  logic [apba_pkg::ADDR_W-1:0]    req_addr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [apba_pkg::ADDR_W-1:0]    granted_addr
);
  import apba_pkg::*;

  localparam int IDX_W = $clog2(POOL_SIZE);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_SRD   = 8'b0000_1000,
    S_SEV   = 8'b0001_0000,
    S_DRD   = 8'b0010_0000,
    S_DEV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  cfg_t              cfg;
  logic [1:0]        cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [IDX_W-1:0]  clr_idx;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] cursor;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] start_pos;
  logic [ADDR_W-1:0] pos_after;
  logic [ADDR_W-1:0] addr_off;
  logic [ADDR_W-1:0] pos_off;
  logic              addr_ok;
  logic              cursor_in;
  logic              out_free;
  logic [1:0]        res_status;
  logic [ADDR_W-1:0] res_grant;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [0:0]        ram_wdata;
  logic [0:0]        ram_rdata;

  apba_cfg #(.POOL_SIZE(POOL_SIZE)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  apba_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign addr_off  = addr_r - cfg.pool_first;
  assign pos_off   = pos - cfg.pool_first;
  assign addr_ok   = in_pool(addr_r, cfg.pool_first, cfg.eff_last);
  assign cursor_in = (cursor >= cfg.dyn_first) && (cursor <= cfg.dyn_last);
  // wrap at the range end; pos below dyn_last cannot overflow
  assign pos_after = (pos == cfg.dyn_last) ? cfg.dyn_first : pos + ADDR_W'(1);
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == IDX_W'(POOL_SIZE - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        case (cmd_r)
          CMD_STATIC:  state_next = (addr_r != '0 && addr_ok) ? S_SRD : S_DONE;
          CMD_DYNAMIC: state_next = cfg.dyn_ok ? S_DRD : S_DONE;
          default:     state_next = S_DONE;
        endcase
      end
      S_SRD: state_next = S_SEV;
      S_SEV: state_next = S_DONE;
      S_DRD: state_next = S_DEV;
      S_DEV: begin
        if (!ram_rdata[0] || pos_after == start_pos) state_next = S_DONE;
        else state_next = S_DRD;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // bitmap port: clear sweep, reclaim write, probe reads, set on a free bit
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx;
    ram_wdata = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_idx;
      end
      S_CHECK: begin
        ram_addr = addr_off[IDX_W-1:0];
        ram_we   = (cmd_r == CMD_RECLAIM) && (addr_r != '0) && addr_ok;
      end
      S_SEV, S_DEV: begin
        ram_we    = !ram_rdata[0];
        ram_wdata = 1'b1;
      end
      S_DRD: ram_addr = pos_off[IDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      cursor    <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + IDX_W'(1);
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg.cursor_load) cursor <= cfg.dyn_first;
      else if (state == S_DEV) cursor <= pos_after;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_r  <= cmd;
          addr_r <= req_addr;
        end
      end
      S_CHECK: begin
        idx       <= addr_off[IDX_W-1:0];
        res_grant <= addr_r;
        pos       <= cursor_in ? cursor : cfg.dyn_first;
        start_pos <= cursor_in ? cursor : cfg.dyn_first;
        case (cmd_r)
          CMD_STATIC, CMD_RECLAIM: begin
            if (addr_r == '0) res_status <= ST_ZERO;
            else if (!addr_ok) res_status <= ST_REJECT;
            else res_status <= ST_OK;
          end
          CMD_DYNAMIC: res_status <= cfg.dyn_ok ? ST_EXHAUSTED : ST_REJECT;
          default:     res_status <= ST_REJECT;
        endcase
      end
      S_SEV: res_status <= ram_rdata[0] ? ST_REJECT : ST_OK;
      S_DRD: idx <= pos_off[IDX_W-1:0];
      S_DEV: begin
        pos <= pos_after;
        if (!ram_rdata[0]) begin
          res_status <= ST_OK;
          res_grant  <= pos;
        end
      end
      S_DONE: begin
        if (out_free) begin
          status       <= res_status;
          granted_addr <= res_grant;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DRD |-> pos >= cfg.dyn_first && pos <= cfg.dyn_last)
    else $error("search position left the dynamic range");

  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && cmd_r == CMD_DYNAMIC && res_status == ST_OK
    |-> res_grant >= cfg.dyn_first && res_grant <= cfg.dyn_last)
    else $error("dynamic grant outside the dynamic range");

  a_exhaust_cursor: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && cmd_r == CMD_DYNAMIC && res_status == ST_EXHAUSTED
    |-> cursor == start_pos)
    else $error("cursor not back at search start after exhausted search");

  a_probe_then_eval: assert property (@(posedge clk) disable iff (rst)
    state == S_DRD |=> state == S_DEV && $stable(pos))
    else $error("probe read not followed by its evaluation");
`endif

endmodule

@@ design/apba_ram.sv @@
// generic single-port ram with registered read
module apba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/apba_cfg.sv @@
// configuration registers, clipped pool end and dynamic range check
module apba_cfg #(
  parameter int POOL_SIZE = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [apba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apba_pkg::ADDR_W-1:0]       cfg_wdata,
  output apba_pkg::cfg_t                    cfg
);
  import apba_pkg::*;

  logic [ADDR_W-1:0] pool_first;
  logic [ADDR_W-1:0] pool_last;
  logic              dyn_enable;
  logic [ADDR_W-1:0] dyn_first;
  logic [ADDR_W-1:0] dyn_last;
  logic [ADDR_W:0]   eff_last;
  logic [ADDR_W:0]   cap;
  logic              cursor_load;

  assign cap = {1'b0, pool_first} + (ADDR_W+1)'(POOL_SIZE - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_first  <= '0;
      pool_last   <= '0;
      dyn_enable  <= 1'b0;
      dyn_first   <= '0;
      dyn_last    <= '0;
      eff_last    <= '0;
      cursor_load <= 1'b0;
    end else begin
      cursor_load <= cfg_we && (cfg_index == REG_DYN_FIRST);
      // clip the pool end to the bitmap size
      eff_last <= ({1'b0, pool_last} > cap) ? cap : {1'b0, pool_last};
      if (cfg_we) begin
        case (cfg_index)
          REG_POOL_FIRST: pool_first <= cfg_wdata;
          REG_POOL_LAST:  pool_last  <= cfg_wdata;
          REG_DYN_ENABLE: dyn_enable <= cfg_wdata[0];
          REG_DYN_FIRST:  dyn_first  <= cfg_wdata;
          REG_DYN_LAST:   dyn_last   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg.pool_first  = pool_first;
    cfg.eff_last    = eff_last;
    cfg.dyn_first   = dyn_first;
    cfg.dyn_last    = dyn_last;
    cfg.cursor_load = cursor_load;
    cfg.dyn_ok      = dyn_enable && (dyn_last >= dyn_first) &&
                      in_pool(dyn_first, pool_first, eff_last) &&
                      in_pool(dyn_last, pool_first, eff_last);
  end

endmodule
